[hdl/frbp_pkg.sv]
// Package for the FIFO reinsertion cache policy with batched promotion.
// Holds widths, configuration codes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none
package frbp_pkg;
    localparam int ID_W          = 32;
    localparam int FREQ_W        = 3;
    localparam int CFG_W         = 16;
    localparam int REINS_W       = 9;
    localparam int ENTRIES_DEF   = 64;
    localparam int LOG_DEPTH_DEF = 4096;

    // configuration register indexes
    localparam logic CFG_BATCH  = 1'b0;
    localparam logic CFG_FLIMIT = 1'b1;

    localparam logic [CFG_W-1:0]  BATCH_RST  = 16'd12;
    localparam logic [FREQ_W-1:0] FLIMIT_RST = 3'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_PRD,
        S_PWAIT,
        S_PNEXT,
        S_MISS,
        S_ERD,
        S_ECHK,
        S_RES
    } t_state;
endpackage
`default_nettype wire

[hdl/frbp_req_if.sv]
// Request channel: valid/ready handshake carrying one object id.
// Depends on frbp_pkg.
`default_nettype none
interface frbp_req_if
    import frbp_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] obj_id;

    modport source (output valid, output obj_id, input ready);
    modport sink   (input valid, input obj_id, output ready);
endinterface
`default_nettype wire

[hdl/frbp_res_if.sv]
// Result channel: valid/ready handshake carrying one policy decision.
// Depends on frbp_pkg.
`default_nettype none
interface frbp_res_if
    import frbp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               hit;
    logic               evict_valid;
    logic [ID_W-1:0]    evicted_id;
    logic [REINS_W-1:0] reinsert_count;
    logic               promotion_done;

    modport source (output valid, output hit, output evict_valid, output evicted_id,
                    output reinsert_count, output promotion_done, input ready);
    modport sink   (input valid, input hit, input evict_valid, input evicted_id,
                    input reinsert_count, input promotion_done, output ready);
endinterface
`default_nettype wire

[hdl/fifo_reinsertion_batched_promotion_top.sv]
// Top level of the FIFO reinsertion cache policy with lazy batched promotion.
// Depends on frbp_pkg, frbp_req_if and frbp_res_if.
//
//   channel   | direction | handshake           | payload
//   i_req     | in        | valid/ready         | obj_id
//   o_res     | out       | valid/ready         | hit, evict_valid, evicted_id,
//             |           |                     | reinsert_count, promotion_done
//   i_cfg_*   | in        | write enable only   | idx selects batch_inserts/freq_limit
//
// Lookup reads the entry memory one slot per cycle until a match or the end.
// A fill miss writes the next free slot; an eviction reads and rewrites each
// visited slot. A batch promotion rescans the entry memory for every logged id.
// One item is in flight at a time.
// Reset clears control state; memories need no clearing pass.
// The output register holds one result; a new item is taken once it is loaded.
`default_nettype none
module fifo_reinsertion_batched_promotion_top
    import frbp_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int HIT_LOG_DEPTH = LOG_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    frbp_req_if.sink              i_req,
    frbp_res_if.source            o_res,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LOG_AW = $clog2(HIT_LOG_DEPTH);
    localparam int FILL_W = $clog2(HIT_LOG_DEPTH + 1);
    localparam int WORD_W = ID_W + FREQ_W;

    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0]  r_batch;
    logic [FREQ_W-1:0] r_flim;

    // memories
    logic [WORD_W-1:0] ent_mem [ENTRIES];
    logic [ID_W-1:0]   log_mem [HIT_LOG_DEPTH];
    logic [WORD_W-1:0] r_rd;
    logic [ID_W-1:0]   r_log_rd;

    // policy state
    logic [CNT_W-1:0]  r_occ;
    logic [IDX_W-1:0]  r_hand;
    logic [LOG_AW-1:0] r_wptr;
    logic [FILL_W-1:0] r_fill;
    logic [CFG_W-1:0]  r_ins;

    // scan and walk control
    logic [ID_W-1:0]   r_key, r_req;
    logic [CNT_W-1:0]  r_idx;
    logic              r_cv;
    logic [IDX_W-1:0]  r_cidx;
    logic              r_pmode;
    logic [LOG_AW-1:0] r_pos;
    logic [FILL_W-1:0] r_pcnt;

    // pending result and output register
    logic               r_hit, r_ev, r_prom;
    logic [ID_W-1:0]    r_evid;
    logic [REINS_W-1:0] r_reins;
    logic               r_ov, r_o_hit, r_o_ev, r_o_prom;
    logic [ID_W-1:0]    r_o_evid;
    logic [REINS_W-1:0] r_o_reins;

    // memory port controls
    logic              e_re, e_we;
    logic [IDX_W-1:0]  e_raddr, e_waddr;
    logic [WORD_W-1:0] e_wdata;
    logic              l_we;

    logic [ID_W-1:0]   rd_id;
    logic [FREQ_W-1:0] rd_freq;
    logic              match, scan_done, do_prom, load_out;
    logic [CFG_W-1:0]  batch_eff;
    logic [LOG_AW-1:0] wptr_nx;
    logic [FILL_W-1:0] fill_nx;
    logic [IDX_W-1:0]  hand_nx;
    logic [CFG_W-1:0]  ins_nx;

    assign rd_id     = r_rd[WORD_W-1:FREQ_W];
    assign rd_freq   = r_rd[FREQ_W-1:0];
    assign match     = r_cv && (rd_id == r_key);
    assign scan_done = !r_cv && (r_idx >= r_occ);
    assign batch_eff = (r_batch == '0) ? CFG_W'(1) : r_batch;
    assign do_prom   = (r_ins >= batch_eff);
    assign wptr_nx   = (r_wptr == LOG_AW'(HIT_LOG_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign fill_nx   = (r_fill == FILL_W'(HIT_LOG_DEPTH)) ? r_fill : r_fill + 1'b1;
    assign hand_nx   = (r_hand == IDX_W'(ENTRIES - 1)) ? '0 : r_hand + 1'b1;
    assign ins_nx    = (r_ins == '1) ? r_ins : r_ins + 1'b1;
    assign load_out  = (r_state == S_RES) && (!r_ov || o_res.ready);

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_ov;
    assign o_res.hit            = r_o_hit;
    assign o_res.evict_valid    = r_o_ev;
    assign o_res.evicted_id     = r_o_evid;
    assign o_res.reinsert_count = r_o_reins;
    assign o_res.promotion_done = r_o_prom;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_SCAN;
            S_SCAN: begin
                if (match)          n_state = r_pmode ? S_PNEXT : S_HIT;
                else if (scan_done) n_state = r_pmode ? S_PNEXT : S_MISS;
            end
            S_HIT:   n_state = do_prom ? S_PRD : S_RES;
            S_PRD:   n_state = S_PWAIT;
            S_PWAIT: n_state = S_SCAN;
            S_PNEXT: n_state = (r_pcnt == FILL_W'(1)) ? S_RES : S_PRD;
            S_MISS:  n_state = (r_occ < CNT_W'(ENTRIES)) ? S_RES : S_ERD;
            S_ERD:   n_state = S_ECHK;
            S_ECHK:  n_state = (rd_freq != '0) ? S_ERD : S_RES;
            S_RES:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        e_re    = 1'b0;
        e_raddr = r_hand;
        e_we    = 1'b0;
        e_waddr = r_hand;
        e_wdata = {r_req, {FREQ_W{1'b0}}};
        l_we    = 1'b0;
        case (r_state)
            S_SCAN: begin
                e_re    = (r_idx < r_occ);
                e_raddr = r_idx[IDX_W-1:0];
                e_we    = r_pmode && match && (rd_freq < r_flim);
                e_waddr = r_cidx;
                e_wdata = {rd_id, rd_freq + 1'b1};
            end
            S_HIT:  l_we = 1'b1;
            S_MISS: begin
                e_we    = (r_occ < CNT_W'(ENTRIES));
                e_waddr = r_occ[IDX_W-1:0];
            end
            S_ERD:  e_re = 1'b1;
            S_ECHK: begin
                e_we = 1'b1;
                if (rd_freq != '0) e_wdata = {rd_id, rd_freq - 1'b1};
            end
            default: ;
        endcase
    end

    // entry memory and hit log memory
    always_ff @(posedge i_clk) begin
        if (e_we) ent_mem[e_waddr] <= e_wdata;
        if (e_re) r_rd <= ent_mem[e_raddr];
        if (l_we) log_mem[r_wptr] <= r_req;
        if (r_state == S_PRD) r_log_rd <= log_mem[r_pos];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch <= BATCH_RST;
            r_flim  <= FLIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BATCH:  r_batch <= i_cfg_data;
                CFG_FLIMIT: r_flim  <= i_cfg_data[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_hand  <= '0;
            r_wptr  <= '0;
            r_fill  <= '0;
            r_ins   <= '0;
            r_cv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)                r_ov <= 1'b1;
            else if (r_ov && o_res.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE:  r_cv <= 1'b0;
                S_SCAN:  r_cv <= (r_idx < r_occ) && !match;
                S_HIT: begin
                    r_wptr <= wptr_nx;
                    r_fill <= fill_nx;
                end
                S_PWAIT: r_cv <= 1'b0;
                S_PNEXT: begin
                    if (r_pcnt == FILL_W'(1)) begin
                        r_wptr <= '0;
                        r_fill <= '0;
                        r_ins  <= '0;
                    end
                end
                S_MISS: begin
                    if (r_occ < CNT_W'(ENTRIES)) begin
                        r_occ <= r_occ + 1'b1;
                        r_ins <= ins_nx;
                    end
                end
                S_ECHK: begin
                    r_hand <= hand_nx;
                    if (rd_freq == '0) r_ins <= ins_nx;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_key   <= i_req.obj_id;
                r_req   <= i_req.obj_id;
                r_idx   <= '0;
                r_pmode <= 1'b0;
                r_hit   <= 1'b0;
                r_ev    <= 1'b0;
                r_evid  <= '0;
                r_reins <= '0;
                r_prom  <= 1'b0;
            end
            S_SCAN: begin
                r_cidx <= r_idx[IDX_W-1:0];
                if (r_idx < r_occ) r_idx <= r_idx + 1'b1;
            end
            S_HIT: begin
                r_hit  <= 1'b1;
                r_pos  <= (fill_nx == FILL_W'(HIT_LOG_DEPTH)) ? wptr_nx : '0;
                r_pcnt <= fill_nx;
            end
            S_PWAIT: begin
                r_key   <= r_log_rd;
                r_idx   <= '0;
                r_pmode <= 1'b1;
            end
            S_PNEXT: begin
                r_pcnt <= r_pcnt - 1'b1;
                r_pos  <= (r_pos == LOG_AW'(HIT_LOG_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                if (r_pcnt == FILL_W'(1)) r_prom <= 1'b1;
            end
            S_ECHK: begin
                if (rd_freq != '0) begin
                    r_reins <= r_reins + 1'b1;
                end else begin
                    r_ev   <= 1'b1;
                    r_evid <= rd_id;
                end
            end
            default: ;
        endcase
        // load the output register
        if (load_out) begin
            r_o_hit   <= r_hit;
            r_o_ev    <= r_ev;
            r_o_evid  <= r_evid;
            r_o_reins <= r_reins;
            r_o_prom  <= r_prom;
        end
    end
endmodule
`default_nettype wire

[hdl/frbp_chk.sv]
// Port-level checker for the FIFO reinsertion policy, bound to the top level.
// Depends on frbp_pkg.
`default_nettype none
module frbp_chk
    import frbp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire logic               i_hit,
    input wire logic               i_evict_valid,
    input wire logic [ID_W-1:0]    i_evicted_id,
    input wire logic [REINS_W-1:0] i_reinsert_count,
    input wire logic               i_promotion_done
);
    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_hit && i_evict_valid))
        else $error("hit with eviction");

    // no eviction means zero id and zero reinsertions
    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_evict_valid) |-> (i_evicted_id == '0 && i_reinsert_count == '0))
        else $error("eviction fields set without eviction");

    // promotion runs only on a hit
    a_prom_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_promotion_done) |-> i_hit)
        else $error("promotion on a miss");

    // a stalled result stays valid and keeps its evicted id
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_evicted_id)))
        else $error("result dropped under stall");
endmodule

bind fifo_reinsertion_batched_promotion_top frbp_chk u_frbp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_hit            (o_res.hit),
    .i_evict_valid    (o_res.evict_valid),
    .i_evicted_id     (o_res.evicted_id),
    .i_reinsert_count (o_res.reinsert_count),
    .i_promotion_done (o_res.promotion_done)
);
`default_nettype wire
